[hw/rtl/cmce_pkg.sv]
// shared types, constants and register indexes of the carriage move command encoder
`timescale 1ns / 1ps

package cmce_pkg;

  // geometry
  localparam int HORZ_STEP = 6;
  localparam int VERT_STEP = 8;
  localparam int POS_BITS  = 12;

  // field widths
  localparam int IN_BITS   = 12;
  localparam int BYTE_BITS = 8;
  localparam int REP_BITS  = 12;
  localparam int CFG_IDX_BITS = 3;

  // reciprocal divide by the step sizes: estimate is low by at most one
  localparam int DIV_SHIFT = POS_BITS;
  localparam int RECIP_W   = POS_BITS + 1;
  localparam int PROD_W    = POS_BITS + RECIP_W;
  localparam int HORZ_RECIP = (1 << DIV_SHIFT) / HORZ_STEP;
  localparam int VERT_RECIP = (1 << DIV_SHIFT) / VERT_STEP;
  localparam logic [POS_BITS-1:0] HORZ_K = POS_BITS'(HORZ_STEP);
  localparam logic [POS_BITS-1:0] VERT_K = POS_BITS'(VERT_STEP);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ESCAPE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLOT_ON  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PLOT_OFF = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOWN     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETURN   = 3'd6;

  // reset values of the byte codes
  localparam logic [BYTE_BITS-1:0] RST_PLOT_ON  = 8'd51;
  localparam logic [BYTE_BITS-1:0] RST_PLOT_OFF = 8'd52;
  localparam logic [BYTE_BITS-1:0] RST_DOWN     = 8'd10;
  localparam logic [BYTE_BITS-1:0] RST_LEFT     = 8'd8;
  localparam logic [BYTE_BITS-1:0] RST_RIGHT    = 8'd32;
  localparam logic [BYTE_BITS-1:0] RST_RETURN   = 8'd13;

  // result slots of one move, in emission order
  localparam int NUM_SLOTS = 9;
  localparam int SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_RET    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_XC     = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_XON    = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_XF     = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_XOFF   = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_YC     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_YON    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_YF     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_YOFF   = 4'd8;

  typedef struct packed {
    logic [IN_BITS-1:0] target_x;
    logic [IN_BITS-1:0] target_y;
  } cmce_in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 escaped;
    logic [REP_BITS-1:0]  repeat_res;
    logic                 last_of_move;
  } cmce_out_t;

  // classified move, as queued for the back end
  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic                 right;
    logic                 up;
    logic [POS_BITS-1:0]  qx;
    logic [POS_BITS-1:0]  rx;
    logic [POS_BITS-1:0]  qy;
    logic [POS_BITS-1:0]  ry;
  } cmce_cmd_t;

  // queue side towards the back end
  typedef struct packed {
    logic      valid;
    cmce_cmd_t head;
  } cmce_q_head_t;

endpackage

[hw/rtl/cmce_front.sv]
// front end: accepts moves, tracks the carriage position and classifies each move
`timescale 1ns / 1ps

module cmce_front import cmce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      move_valid,
  output logic      move_ready,
  input  cmce_in_t  move,
  output logic      q_push,
  output cmce_cmd_t q_data,
  input  logic      q_full
);

  logic [POS_BITS-1:0] cur_x;
  logic [POS_BITS-1:0] cur_y;

  // first stage: distances and directions
  logic                a_valid;
  logic                a_ret;
  logic                a_right;
  logic                a_up;
  logic [POS_BITS-1:0] a_dx;
  logic [POS_BITS-1:0] a_dy;

  // second stage: quotient estimates
  logic                b_valid;
  logic                b_ret;
  logic                b_right;
  logic                b_up;
  logic [POS_BITS-1:0] b_dx;
  logic [POS_BITS-1:0] b_dy;
  logic [POS_BITS-1:0] b_qx;
  logic [POS_BITS-1:0] b_qy;

  logic                a_go;
  logic                b_go;
  logic                accept;
  logic [POS_BITS-1:0] tx;
  logic [POS_BITS-1:0] ty;
  logic [POS_BITS-1:0] fx;
  logic                ret;
  logic                right;
  logic                up;
  logic                moving;
  logic [POS_BITS-1:0] dx;
  logic [POS_BITS-1:0] dy;
  logic [PROD_W-1:0]   prod_x;
  logic [PROD_W-1:0]   prod_y;
  logic [POS_BITS-1:0] rem_x;
  logic [POS_BITS-1:0] rem_y;
  logic                fix_x;
  logic                fix_y;
  logic [POS_BITS-1:0] qx;
  logic [POS_BITS-1:0] qy;
  logic [POS_BITS-1:0] rx;
  logic [POS_BITS-1:0] ry;

  // stage flow
  assign b_go       = !b_valid || !q_full;
  assign a_go       = !a_valid || b_go;
  assign move_ready = a_go;
  assign accept     = move_valid && move_ready;

  // classify against the current position
  always_comb begin
    tx     = POS_BITS'(move.target_x);
    ty     = POS_BITS'(move.target_y);
    ret    = tx < (cur_x >> 1);
    fx     = ret ? '0 : cur_x;
    right  = fx < tx;
    up     = cur_y < ty;
    dx     = right ? (tx - fx) : (fx - tx);
    dy     = up ? (ty - cur_y) : (cur_y - ty);
    moving = (tx != cur_x) || (ty != cur_y);
  end

  // position follows every accepted target
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
    end else if (accept) begin
      cur_x <= tx;
      cur_y <= ty;
    end
  end

  // stage a, moves with no motion are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_go) begin
      a_valid <= accept && moving;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      a_ret   <= ret;
      a_right <= right;
      a_up    <= up;
      a_dx    <= dx;
      a_dy    <= dy;
    end
  end

  // reciprocal multiply
  assign prod_x = PROD_W'(a_dx) * PROD_W'(HORZ_RECIP);
  assign prod_y = PROD_W'(a_dy) * PROD_W'(VERT_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_go) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      b_ret   <= a_ret;
      b_right <= a_right;
      b_up    <= a_up;
      b_dx    <= a_dx;
      b_dy    <= a_dy;
      b_qx    <= prod_x[DIV_SHIFT +: POS_BITS];
      b_qy    <= prod_y[DIV_SHIFT +: POS_BITS];
    end
  end

  // one correction step on the quotient, remainder falls out
  always_comb begin
    rem_x = b_dx - b_qx * HORZ_K;
    rem_y = b_dy - b_qy * VERT_K;
    fix_x = rem_x >= HORZ_K;
    fix_y = rem_y >= VERT_K;
    qx    = fix_x ? (b_qx + 1'b1) : b_qx;
    qy    = fix_y ? (b_qy + 1'b1) : b_qy;
    rx    = fix_x ? (rem_x - HORZ_K) : rem_x;
    ry    = fix_y ? (rem_y - VERT_K) : rem_y;
  end

  // build the slot list for the back end
  always_comb begin
    q_data              = '0;
    q_data.slots[SLOT_RET]  = b_ret;
    q_data.slots[SLOT_XC]   = qx != '0;
    q_data.slots[SLOT_XON]  = 1'b1;
    q_data.slots[SLOT_XF]   = rx != '0;
    q_data.slots[SLOT_XOFF] = 1'b1;
    q_data.slots[SLOT_YC]   = qy != '0;
    q_data.slots[SLOT_YON]  = 1'b1;
    q_data.slots[SLOT_YF]   = ry != '0;
    q_data.slots[SLOT_YOFF] = 1'b1;
    q_data.right        = b_right;
    q_data.up           = b_up;
    q_data.qx           = qx;
    q_data.rx           = rx;
    q_data.qy           = qy;
    q_data.ry           = ry;
  end

  assign q_push = b_valid && !q_full;

endmodule

[hw/rtl/cmce_queue.sv]
// short queue of classified moves between front and back end
`timescale 1ns / 1ps

module cmce_queue import cmce_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmce_cmd_t    push_data,
  output logic         full,
  input  logic         pop,
  output cmce_q_head_t head
);

  cmce_cmd_t               mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;

  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] n;
    n = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign full       = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/cmce_back.sv]
// back end: byte code regs and sequencer, one run-length item a cycle unless res stalls
`timescale 1ns / 1ps

module cmce_back import cmce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [BYTE_BITS-1:0]    cfg_data,
  input  cmce_q_head_t            head,
  output logic                    pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output cmce_out_t               res
);

  logic [BYTE_BITS-1:0] code_plot_on;
  logic [BYTE_BITS-1:0] code_plot_off;
  logic [BYTE_BITS-1:0] code_down;
  logic [BYTE_BITS-1:0] code_left;
  logic [BYTE_BITS-1:0] code_right;
  logic [BYTE_BITS-1:0] code_return;

  logic [NUM_SLOTS-1:0] pending;
  cmce_cmd_t            cur;

  logic [NUM_SLOTS-1:0] low_bit;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    sel;
  logic                 found;
  logic                 emit;
  logic [BYTE_BITS-1:0] x_byte;
  cmce_out_t            item;

  // configuration writes, escape byte itself is inserted downstream
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_plot_on  <= RST_PLOT_ON;
      code_plot_off <= RST_PLOT_OFF;
      code_down     <= RST_DOWN;
      code_left     <= RST_LEFT;
      code_right    <= RST_RIGHT;
      code_return   <= RST_RETURN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ESCAPE:   ;
        REG_PLOT_ON:  code_plot_on  <= cfg_data;
        REG_PLOT_OFF: code_plot_off <= cfg_data;
        REG_DOWN:     code_down     <= cfg_data;
        REG_LEFT:     code_left     <= cfg_data;
        REG_RIGHT:    code_right    <= cfg_data;
        REG_RETURN:   code_return   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // next slot to emit
  always_comb begin
    low_bit = pending & (~pending + 1'b1);
    rest    = pending & ~low_bit;
    sel     = '0;
    found   = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pending[i] && !found) begin
        sel   = SLOT_W'(i);
        found = 1'b1;
      end
    end
  end

  assign emit = found && (!res_valid || res_ready);
  assign pop  = head.valid && (!found || (emit && rest == '0));

  // slot decode
  always_comb begin
    x_byte            = cur.right ? code_right : code_left;
    item              = '0;
    item.last_of_move = rest == '0;
    unique case (sel)
      SLOT_RET: begin
        item.out_byte   = code_return;
        item.repeat_res = REP_BITS'(1);
      end
      SLOT_XC: begin
        item.out_byte   = x_byte;
        item.repeat_res = REP_BITS'(cur.qx);
      end
      SLOT_XON, SLOT_YON: begin
        item.out_byte   = code_plot_on;
        item.escaped    = 1'b1;
        item.repeat_res = REP_BITS'(1);
      end
      SLOT_XF: begin
        item.out_byte   = x_byte;
        item.repeat_res = REP_BITS'(cur.rx);
      end
      SLOT_XOFF, SLOT_YOFF: begin
        item.out_byte   = code_plot_off;
        item.escaped    = 1'b1;
        item.repeat_res = REP_BITS'(1);
      end
      SLOT_YC: begin
        item.out_byte   = code_down;
        item.escaped    = cur.up;
        item.repeat_res = REP_BITS'(cur.qy);
      end
      SLOT_YF: begin
        item.out_byte   = code_down;
        item.escaped    = cur.up;
        item.repeat_res = REP_BITS'(cur.ry);
      end
      default: ;
    endcase
  end

  // sequencer, takes the next move as the last slot goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (pop) begin
      pending <= head.head.slots;
    end else if (emit) begin
      pending <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= item;
    end
  end

endmodule

[hw/rtl/carriage_move_command_encoder_unit.sv]
// top level of the carriage move command encoder
//
//   channel | beat                         | handshake
//   --------+------------------------------+---------------------
//   move    | target_x, target_y           | move_valid/move_ready
//   res     | out_byte, escaped, repeat_res, last_of_move | res_valid/res_ready
//   cfg     | cfg_index, cfg_data          | cfg_valid/cfg_ready
//
// a move gives 4 to 9 result beats, issued by the back-end sequencer
// a move with no motion gives no beats
// a move passes stages a and b, the queue and the sequencer to the output register
// moves are taken every cycle while the two-entry queue has room
// sync reset clears position and all valid flags, resets codes; cfg_ready is always high
`timescale 1ns / 1ps

module carriage_move_command_encoder_unit import cmce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    move_valid,
  output logic                    move_ready,
  input  cmce_in_t                move,
  output logic                    res_valid,
  input  logic                    res_ready,
  output cmce_out_t               res,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [BYTE_BITS-1:0]    cfg_data
);

  logic         q_push;
  cmce_cmd_t    q_data;
  logic         q_full;
  logic         q_pop;
  cmce_q_head_t q_head;

  // classify moves
  cmce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .move_valid (move_valid),
    .move_ready (move_ready),
    .move       (move),
    .q_push     (q_push),
    .q_data     (q_data),
    .q_full     (q_full)
  );

  // decouple the two sides
  cmce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // emit result beats
  cmce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[hw/rtl/cmce_checker.sv]
// port checker for the carriage move command encoder, bound to the top level
`timescale 1ns / 1ps

module cmce_checker import cmce_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      move_valid,
  input logic      move_ready,
  input logic      res_valid,
  input logic      res_ready,
  input cmce_out_t res
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // run lengths are never empty
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.repeat_res != '0)
    else $error("zero run length");

  // a move always closes with a single escaped byte, as the plot-off is
  a_last_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last_of_move |-> res.escaped && res.repeat_res == REP_BITS'(1))
    else $error("final beat of a move is not a single escaped byte");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat straight after reset");

  // handshake outputs are always known out of reset
  a_known_hs: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({move_ready, res_valid}) && (!move_valid || !$isunknown(move_ready)))
    else $error("unknown handshake output");

endmodule

bind carriage_move_command_encoder_unit cmce_checker u_cmce_checker (
  .clk        (clk),
  .rst        (rst),
  .move_valid (move_valid),
  .move_ready (move_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);
